// File: hw/rtl/nerp_pkg.sv
// ----------------------------------------------------------------------------
// nerp_pkg
// Shared types and constants of the note event recorder and player.
// ----------------------------------------------------------------------------
package nerp_pkg;

  localparam int SLOTS        = 4;
  localparam int SLOT_W       = 2;
  localparam int EPS          = 1024;
  localparam int EPS_W        = 10;
  localparam int CNT_W        = EPS_W + 1;
  localparam int EPT          = 62;
  localparam int EMIT_W       = 6;
  localparam int TIME_W       = 20;
  localparam int ADDR_W       = SLOT_W + EPS_W;
  localparam int ENTRY_W      = 35;
  localparam int PCT          = 100;
  localparam int NUM_W        = TIME_W + 7;
  localparam logic [TIME_W-1:0] TIME_MAX    = '1;
  localparam logic [TIME_W-1:0] LIMIT_RESET = 20'd180000;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_START_REC  = 3'd1,
    OP_STOP_REC   = 3'd2,
    OP_REC_EVENT  = 3'd3,
    OP_START_PLAY = 3'd4,
    OP_PAUSE      = 3'd5,
    OP_RESUME     = 3'd6,
    OP_STOP_PLAY  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_REC   = 2'd1,
    MODE_PLAY  = 2'd2,
    MODE_PAUSE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    K_STATUS   = 2'd0,
    K_NOTE_ON  = 2'd1,
    K_NOTE_OFF = 2'd2,
    K_ALL_OFF  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IN, S_EXEC, S_RD, S_CHK, S_END, S_ANO, S_PREP, S_DIV, S_STAT
  } state_t;

endpackage

// File: hw/rtl/nerp_if.sv
// ----------------------------------------------------------------------------
// nerp channel interfaces
// Command, result and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
interface nerp_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [2:0] slot;
  logic [6:0] note_in;
  logic [6:0] velocity_in;
  logic       event_kind;
  modport source (output valid, opcode, slot, note_in, velocity_in, event_kind, input ready);
  modport sink (input valid, opcode, slot, note_in, velocity_in, event_kind, output ready);
endinterface

interface nerp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [6:0]  note_out;
  logic [6:0]  velocity_out;
  logic [1:0]  mode;
  logic [2:0]  current_slot;
  logic [19:0] current_time;
  logic [6:0]  progress;
  logic [10:0] count_out;
  logic [19:0] duration_out;
  logic        last;
  modport source (output valid, kind, note_out, velocity_out, mode, current_slot,
                  current_time, progress, count_out, duration_out, last, input ready);
  modport sink (input valid, kind, note_out, velocity_out, mode, current_slot,
                current_time, progress, count_out, duration_out, last, output ready);
endinterface

interface nerp_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] record_limit;
  modport source (output valid, record_limit, input ready);
  modport sink (input valid, record_limit, output ready);
endinterface

// File: hw/rtl/note_event_record_playback.sv
// ----------------------------------------------------------------------------
// note_event_record_playback
// Records note events into slots of an event memory and plays them back.
// ----------------------------------------------------------------------------
// Commands arrive as transactions on cmd; each one yields zero or more note or
// all-notes-off items on res, followed by one status item with last set.
// The record limit is written through cfg, which is always ready.
// One command is processed at a time. A command is accepted, executed, then
// passes through the progress division (one quotient bit per cycle) and
// the status item. A pause during play or a stop of play adds its
// all-notes-off item. A tick during playback adds, per played event, a
// memory read, then compare and emit; then a final read and compare, a check
// for the end of play, and an all-notes-off item when play ends.
// The event memory is single-ported with registered read data.
// Reset is synchronous; it clears counts, durations, mode, slot and time, and
// restores the default record limit. The event memory is not cleared.
// When the receiver stalls, the output register holds its item and the
// sequencer waits; no new command is taken until the status item is loaded.
// ----------------------------------------------------------------------------
module note_event_record_playback (
  input  logic             clk,
  input  logic             rst,
  nerp_cmd_if.sink         cmd,
  nerp_res_if.source       res,
  nerp_cfg_if.sink         cfg
);

  nerp_pkg::state_t state, state_next;
  nerp_pkg::mode_t  mode;
  nerp_pkg::op_t    op;

  logic [2:0]                      slot_in;
  logic [6:0]                      note_r;
  logic [6:0]                      vel_r;
  logic                            evk_r;
  logic [nerp_pkg::SLOT_W-1:0]     cs;
  logic [nerp_pkg::TIME_W-1:0]     elapsed;
  logic [nerp_pkg::CNT_W-1:0]      pidx;
  logic [nerp_pkg::EMIT_W-1:0]     emitted;
  logic [nerp_pkg::TIME_W-1:0]     limit;
  logic [nerp_pkg::CNT_W-1:0]      counts [nerp_pkg::SLOTS];
  logic [nerp_pkg::TIME_W-1:0]     durs [nerp_pkg::SLOTS];
  logic [nerp_pkg::ENTRY_W-1:0]    mem [2**nerp_pkg::ADDR_W];
  logic [nerp_pkg::ENTRY_W-1:0]    rdata;
  logic [nerp_pkg::NUM_W-1:0]      num;
  logic [6:0]                      quo;
  logic [2:0]                      dbit;
  logic                            sat;

  logic                            out_free;
  logic                            res_load;
  logic                            slot_ok;
  logic [nerp_pkg::SLOT_W-1:0]     sidx;
  logic [nerp_pkg::CNT_W-1:0]      cnt;
  logic [nerp_pkg::TIME_W-1:0]     dur;
  logic [nerp_pkg::TIME_W-1:0]     t_bump;
  logic [nerp_pkg::TIME_W-1:0]     t_stat;
  logic                            more;
  logic                            due;
  logic [nerp_pkg::NUM_W-1:0]      dstep;
  logic                            mem_re;

  assign out_free = !res.valid || res.ready;
  assign res_load = out_free && ((state == nerp_pkg::S_CHK && due) ||
                                 state == nerp_pkg::S_ANO || state == nerp_pkg::S_STAT);
  assign slot_ok  = {1'b0, slot_in} < 4'(nerp_pkg::SLOTS);
  assign sidx     = slot_in[nerp_pkg::SLOT_W-1:0];
  assign cnt      = counts[cs];
  assign dur      = durs[cs];
  assign t_bump   = (elapsed == nerp_pkg::TIME_MAX) ? elapsed : elapsed + 1'b1;
  assign t_stat   = (mode == nerp_pkg::MODE_IDLE) ? '0 : elapsed;
  assign more     = (pidx < cnt) && (emitted < nerp_pkg::EMIT_W'(nerp_pkg::EPT));
  assign due      = rdata[nerp_pkg::TIME_W-1:0] <= elapsed;
  assign dstep    = nerp_pkg::NUM_W'(dur) << dbit;

  always_comb begin
    state_next = state;
    unique case (state)
      nerp_pkg::S_IN: if (cmd.valid) state_next = nerp_pkg::S_EXEC;
      nerp_pkg::S_EXEC: begin
        unique case (op)
          nerp_pkg::OP_TICK:
            state_next = (mode == nerp_pkg::MODE_PLAY) ? nerp_pkg::S_RD : nerp_pkg::S_PREP;
          nerp_pkg::OP_PAUSE:
            state_next = (mode == nerp_pkg::MODE_PLAY) ? nerp_pkg::S_ANO : nerp_pkg::S_PREP;
          nerp_pkg::OP_STOP_PLAY: state_next = nerp_pkg::S_ANO;
          default: state_next = nerp_pkg::S_PREP;
        endcase
      end
      nerp_pkg::S_RD: state_next = more ? nerp_pkg::S_CHK : nerp_pkg::S_END;
      nerp_pkg::S_CHK: begin
        if (!due) state_next = nerp_pkg::S_END;
        else if (out_free) state_next = nerp_pkg::S_RD;
      end
      nerp_pkg::S_END: state_next = (pidx >= cnt) ? nerp_pkg::S_ANO : nerp_pkg::S_PREP;
      nerp_pkg::S_ANO: if (out_free) state_next = nerp_pkg::S_PREP;
      nerp_pkg::S_PREP: state_next = nerp_pkg::S_DIV;
      nerp_pkg::S_DIV: if (dbit == 3'd0) state_next = nerp_pkg::S_STAT;
      nerp_pkg::S_STAT: if (out_free) state_next = nerp_pkg::S_IN;
      default: state_next = nerp_pkg::S_IN;
    endcase
  end

  always_comb begin
    cmd.ready = (state == nerp_pkg::S_IN);
    cfg.ready = 1'b1;
    mem_re    = (state == nerp_pkg::S_RD) && more;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= nerp_pkg::S_IN;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == nerp_pkg::S_EXEC && op == nerp_pkg::OP_REC_EVENT &&
        mode == nerp_pkg::MODE_REC && cnt < nerp_pkg::CNT_W'(nerp_pkg::EPS)) begin
      mem[{cs, cnt[nerp_pkg::EPS_W-1:0]}] <= {evk_r, vel_r, note_r, elapsed};
    end
    if (mem_re) rdata <= mem[{cs, pidx[nerp_pkg::EPS_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (state == nerp_pkg::S_IN && cmd.valid) begin
      op      <= nerp_pkg::op_t'(cmd.opcode);
      slot_in <= cmd.slot;
      note_r  <= cmd.note_in;
      vel_r   <= cmd.velocity_in;
      evk_r   <= cmd.event_kind;
    end
    if (state == nerp_pkg::S_PREP) begin
      num  <= nerp_pkg::NUM_W'(t_stat) * nerp_pkg::NUM_W'(nerp_pkg::PCT);
      quo  <= '0;
      dbit <= 3'd6;
      sat  <= t_stat >= dur;
    end
    if (state == nerp_pkg::S_DIV) begin
      if (num >= dstep) begin
        num       <= num - dstep;
        quo[dbit] <= 1'b1;
      end
      dbit <= dbit - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= nerp_pkg::MODE_IDLE;
      cs      <= '0;
      elapsed <= '0;
      pidx    <= '0;
      emitted <= '0;
      limit   <= nerp_pkg::LIMIT_RESET;
      for (int i = 0; i < nerp_pkg::SLOTS; i++) begin
        counts[i] <= '0;
        durs[i]   <= '0;
      end
      res.valid <= 1'b0;
    end else begin
      if (cfg.valid) limit <= cfg.record_limit;
      if (res_load) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      unique case (state)
        nerp_pkg::S_EXEC: begin
          case (op)
            nerp_pkg::OP_TICK: begin
              if (mode == nerp_pkg::MODE_REC) begin
                elapsed <= t_bump;
                if (t_bump >= limit) begin
                  durs[cs] <= t_bump;
                  mode     <= nerp_pkg::MODE_IDLE;
                end
              end else if (mode == nerp_pkg::MODE_PLAY) begin
                elapsed <= t_bump;
                emitted <= '0;
              end
            end
            nerp_pkg::OP_START_REC: begin
              if (slot_ok) begin
                cs           <= sidx;
                counts[sidx] <= '0;
                durs[sidx]   <= '0;
                elapsed      <= '0;
                mode         <= nerp_pkg::MODE_REC;
              end
            end
            nerp_pkg::OP_STOP_REC: begin
              if (mode == nerp_pkg::MODE_REC) begin
                durs[cs] <= elapsed;
                mode     <= nerp_pkg::MODE_IDLE;
              end
            end
            nerp_pkg::OP_REC_EVENT: begin
              if (mode == nerp_pkg::MODE_REC) begin
                if (cnt < nerp_pkg::CNT_W'(nerp_pkg::EPS)) begin
                  counts[cs] <= cnt + 1'b1;
                end else begin
                  durs[cs] <= elapsed;
                  mode     <= nerp_pkg::MODE_IDLE;
                end
              end
            end
            nerp_pkg::OP_START_PLAY: begin
              if (slot_ok && counts[sidx] != '0) begin
                cs      <= sidx;
                pidx    <= '0;
                elapsed <= '0;
                mode    <= nerp_pkg::MODE_PLAY;
              end
            end
            nerp_pkg::OP_PAUSE: if (mode == nerp_pkg::MODE_PLAY) mode <= nerp_pkg::MODE_PAUSE;
            nerp_pkg::OP_RESUME: if (mode == nerp_pkg::MODE_PAUSE) mode <= nerp_pkg::MODE_PLAY;
            default: mode <= nerp_pkg::MODE_IDLE;
          endcase
        end
        nerp_pkg::S_CHK: begin
          if (due && out_free) begin
            res.kind         <= rdata[34] ? nerp_pkg::K_NOTE_ON : nerp_pkg::K_NOTE_OFF;
            res.note_out     <= rdata[26:20];
            res.velocity_out <= rdata[34] ? rdata[33:27] : 7'd0;
            res.mode         <= '0;
            res.current_slot <= '0;
            res.current_time <= '0;
            res.progress     <= '0;
            res.count_out    <= '0;
            res.duration_out <= '0;
            res.last         <= 1'b0;
            pidx             <= pidx + 1'b1;
            emitted          <= emitted + 1'b1;
          end
        end
        nerp_pkg::S_END: if (pidx >= cnt) mode <= nerp_pkg::MODE_IDLE;
        nerp_pkg::S_ANO: begin
          if (out_free) begin
            res.kind         <= nerp_pkg::K_ALL_OFF;
            res.note_out     <= '0;
            res.velocity_out <= '0;
            res.mode         <= '0;
            res.current_slot <= '0;
            res.current_time <= '0;
            res.progress     <= '0;
            res.count_out    <= '0;
            res.duration_out <= '0;
            res.last         <= 1'b0;
          end
        end
        nerp_pkg::S_STAT: begin
          if (out_free) begin
            res.kind         <= nerp_pkg::K_STATUS;
            res.note_out     <= '0;
            res.velocity_out <= '0;
            res.mode         <= mode;
            res.current_slot <= 3'(cs);
            res.current_time <= t_stat;
            res.progress     <= ((mode == nerp_pkg::MODE_PLAY || mode == nerp_pkg::MODE_PAUSE)
                                 && dur != '0) ? (sat ? 7'(nerp_pkg::PCT) : quo) : 7'd0;
            res.count_out    <= cnt;
            res.duration_out <= dur;
            res.last         <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_chk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == nerp_pkg::S_CHK |-> pidx < cnt)
    else $error("event read beyond slot count");

  a_emit_cap: assert property (@(posedge clk) disable iff (rst)
    emitted <= nerp_pkg::EMIT_W'(nerp_pkg::EPT))
    else $error("too many events emitted in one tick");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= nerp_pkg::CNT_W'(nerp_pkg::EPS))
    else $error("slot count above capacity");

  a_last_status: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.last |-> res.kind == nerp_pkg::K_STATUS)
    else $error("closing item is not a status item");

endmodule
